@@ rtl/sha1_pkg.sv @@
// Shared types, constants and round functions of the SHA-1 engine.
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int unsigned WordW      = 32;
    localparam int unsigned ChainWords = 5;
    localparam int unsigned SchedWords = 16;
    localparam int unsigned RoundCount = 80;
    localparam int unsigned LenPos     = 56;

    typedef logic [WordW-1:0] word_t;
    typedef logic [6:0]       round_idx_t;
    typedef logic [5:0]       fill_t;
    typedef logic [2:0]       word_idx_t;
    typedef word_t [ChainWords-1:0] chain_t;

    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hEFCDAB89;
    localparam word_t IV2 = 32'h98BADCFE;
    localparam word_t IV3 = 32'h10325476;
    localparam word_t IV4 = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam round_idx_t LAST_ROUND = round_idx_t'(RoundCount - 1);
    localparam fill_t      LAST_FILL  = fill_t'(63);
    localparam fill_t      LEN_FILL   = fill_t'(LenPos);
    localparam word_idx_t  LAST_WORD  = word_idx_t'(ChainWords - 1);

    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic add;
    } rnd_ctrl_t;

    typedef struct packed {
        logic       shift_byte;
        logic       step;
        logic [7:0] din;
    } sched_ctrl_t;

    function automatic word_t round_f(round_idx_t idx, word_t b, word_t c, word_t d);
        word_t f;
        if (idx < round_idx_t'(20)) begin
            f = (b & c) | (~b & d);
        end else if (idx < round_idx_t'(40)) begin
            f = b ^ c ^ d;
        end else if (idx < round_idx_t'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(round_idx_t idx);
        word_t k;
        if (idx < round_idx_t'(20)) begin
            k = K0;
        end else if (idx < round_idx_t'(40)) begin
            k = K1;
        end else if (idx < round_idx_t'(60)) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

endpackage

@@ rtl/sha1_msg_sched.sv @@
// Block buffer and message schedule: byte shift line that becomes the W window.
`timescale 1ns / 1ps

module sha1_msg_sched
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  sched_ctrl_t ctrl,
    output word_t       w_head
);

    word_t w_reg [SchedWords];
    word_t w_mix;
    word_t w_new;

    assign w_mix  = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new  = {w_mix[30:0], w_mix[31]};
    assign w_head = w_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.shift_byte) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_reg[SchedWords-1] <= {w_reg[SchedWords-1][23:0], ctrl.din};
        end else if (ctrl.step) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[SchedWords-1] <= w_new;
        end
    end

endmodule

@@ rtl/sha1_round.sv @@
// Shared SHA-1 round unit with working variables and chaining words.
`timescale 1ns / 1ps

module sha1_round
    import sha1_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  rnd_ctrl_t  ctrl,
    input  round_idx_t round_idx,
    input  word_t      w_in,
    output chain_t     chain
);

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    chain_t chain_reg;
    word_t t_sum;

    assign t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(round_idx, b_reg, c_reg, d_reg)
                 + e_reg + round_k(round_idx) + w_in;
    assign chain = chain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.init) begin
            chain_reg <= {IV4, IV3, IV2, IV1, IV0};
        end else if (ctrl.add) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (ctrl.step) begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

@@ rtl/sha1_hash_engine.sv @@
// Top level of the streaming SHA-1 engine: sequencer, padding and digest output.
//
// Input channel (s_): one item per message byte. s_tdata carries the byte,
// s_tuser says the byte belongs to the message, s_tlast ends the message.
// An item with s_tlast and no byte is allowed, so an empty message works.
// Output channel (m_): five items per message, the digest words with chain
// word 0 first; m_tlast marks the fifth word.
// A byte item is accepted while s_tready is high; the item that completes a
// 64-byte block starts the load, 80 rounds and chain add before s_tready returns.
// The single round unit, one round per cycle, sets the block time.
// On message end the padding bytes shift in one per cycle (up to 64 per block)
// and each padded block is compressed, one or two in all; then the five words
// are offered, and the finish also waits while the receiver holds m_tready low.
// While the receiver stalls, the current word holds on m_tdata and no input
// item is accepted. After the fifth word the engine returns to the initial
// hash values, zero length and an empty block.
// Reset (aresetn low, synchronous) loads the initial hash values, clears the
// length and fill counters and leaves the engine ready for a new message.
`timescale 1ns / 1ps

module sha1_hash_engine
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast
);

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_ADD, S_OUT} state_t;

    state_t      state_reg, state_next;
    fill_t       fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    round_idx_t  round_reg, round_next;
    word_idx_t   word_reg, word_next;
    logic        fin_reg, fin_next;
    logic        first_reg, first_next;
    logic        lenok_reg, lenok_next;
    logic        last_reg, last_next;

    sched_ctrl_t sched_ctrl;
    rnd_ctrl_t   rnd_ctrl;
    word_t       w_head;
    chain_t      chain;

    sha1_msg_sched u_sched (
        .aclk   (aclk),
        .ctrl   (sched_ctrl),
        .w_head (w_head)
    );

    sha1_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rnd_ctrl),
        .round_idx (round_reg),
        .w_in      (w_head),
        .chain     (chain)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = chain[word_reg];
    assign m_tlast  = (word_reg == LAST_WORD);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        round_next = round_reg;
        word_next  = word_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        lenok_next = lenok_reg;
        last_next  = last_reg;
        sched_ctrl = '0;
        rnd_ctrl   = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        sched_ctrl.shift_byte = 1'b1;
                        sched_ctrl.din        = s_tdata;
                        fill_next             = fill_reg + fill_t'(1);
                        count_next            = count_reg + 64'd8;
                    end
                    if (s_tuser && fill_reg == LAST_FILL) begin
                        state_next    = S_COMP;
                        rnd_ctrl.load = 1'b1;
                        round_next    = '0;
                        fin_next      = s_tlast;
                        first_next    = 1'b1;
                        lenok_next    = 1'b0;
                        last_next     = 1'b0;
                    end else if (s_tlast) begin
                        state_next = S_PAD;
                        fin_next   = 1'b1;
                        first_next = 1'b1;
                        lenok_next = 1'b0;
                    end
                end
            end
            S_PAD: begin
                sched_ctrl.shift_byte = 1'b1;
                fill_next             = fill_reg + fill_t'(1);
                if (first_reg) begin
                    sched_ctrl.din = PAD_BYTE;
                    first_next     = 1'b0;
                    lenok_next     = (fill_reg < LEN_FILL);
                end else if (lenok_reg && fill_reg >= LEN_FILL) begin
                    sched_ctrl.din = count_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end else begin
                    sched_ctrl.din = 8'h00;
                end
                if (fill_reg == LAST_FILL) begin
                    state_next    = S_COMP;
                    rnd_ctrl.load = 1'b1;
                    round_next    = '0;
                    last_next     = lenok_next;
                end
            end
            S_COMP: begin
                rnd_ctrl.step   = 1'b1;
                sched_ctrl.step = 1'b1;
                round_next      = round_reg + round_idx_t'(1);
                if (round_reg == LAST_ROUND) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                rnd_ctrl.add = 1'b1;
                if (!fin_reg) begin
                    state_next = S_IDLE;
                end else if (last_reg) begin
                    state_next = S_OUT;
                    word_next  = '0;
                end else begin
                    state_next = S_PAD;
                    if (!first_reg) begin
                        lenok_next = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    word_next = word_reg + word_idx_t'(1);
                    if (word_reg == LAST_WORD) begin
                        state_next    = S_IDLE;
                        rnd_ctrl.init = 1'b1;
                        count_next    = '0;
                        fill_next     = '0;
                        fin_next      = 1'b0;
                        word_next     = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            word_reg  <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            lenok_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            round_reg <= round_next;
            word_reg  <= word_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            lenok_reg <= lenok_next;
            last_reg  <= last_next;
        end
    end

endmodule
